// ===== design/fcbpm_pkg.sv =====
package fcbpm_pkg;

	localparam int PIX_W  = 16;
	localparam int LUM_W  = 16;
	localparam int STR_W  = 9;
	localparam int DITH_W = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Rec.601 weights, Q24 per channel maximum
	localparam logic [17:0] LUMA_KR = 18'd161819;
	localparam logic [17:0] LUMA_KG = 18'd156321;
	localparam logic [17:0] LUMA_KB = 18'd61697;

	// band bounds in Q0.16 (upper bound of the top band lies past full scale)
	localparam logic [16:0] BAND1_LO = 17'd6554;
	localparam logic [16:0] BAND1_HI = 17'd26214;
	localparam logic [16:0] BAND1_R  = 17'd9830;
	localparam logic [16:0] BAND2_LO = 17'd21627;
	localparam logic [16:0] BAND2_HI = 17'd43909;
	localparam logic [16:0] BAND2_R  = 17'd11141;
	localparam logic [16:0] BAND3_LO = 17'd6554;
	localparam logic [16:0] BAND3_HI = 17'd72090;
	localparam logic [16:0] BAND3_R  = 17'd32768;
	localparam logic [16:0] BIAS_POINT = 17'd42598;

	localparam logic [STR_W-1:0] FULL_WEIGHT = 9'd256;

	localparam logic [PIX_W-1:0] DARKEST_RST  = 16'd6339;
	localparam logic [PIX_W-1:0] DARK_RST     = 16'd13062;
	localparam logic [PIX_W-1:0] LIGHT_RST    = 16'd36234;
	localparam logic [PIX_W-1:0] LIGHTEST_RST = 16'd40417;
	localparam logic [STR_W-1:0] STRENGTH_RST = 9'd256;

	// row-major, index {row, column}
	localparam logic [DITH_W-1:0] BAYER [16] = '{
		4'd0,  4'd8,  4'd2,  4'd10,
		4'd12, 4'd4,  4'd14, 4'd6,
		4'd3,  4'd11, 4'd1,  4'd9,
		4'd15, 4'd7,  4'd13, 4'd5
	};

	typedef enum logic [2:0] {
		REG_DARKEST  = 3'd0,
		REG_DARK     = 3'd1,
		REG_LIGHT    = 3'd2,
		REG_LIGHTEST = 3'd3,
		REG_STRENGTH = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		PAL_DARKEST  = 2'd0,
		PAL_DARK     = 2'd1,
		PAL_LIGHT    = 2'd2,
		PAL_LIGHTEST = 2'd3
	} pal_sel_t;

	typedef struct packed {
		logic [PIX_W-1:0] darkest;
		logic [PIX_W-1:0] dark;
		logic [PIX_W-1:0] light;
		logic [PIX_W-1:0] lightest;
		logic [STR_W-1:0] strength;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel;
		logic [STR_W-1:0]  strength;
		logic [DITH_W-1:0] dither;
		logic [LUM_W-1:0]  lum;
	} luma_stage_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [STR_W-1:0] strength;
		pal_sel_t         sel;
	} sel_stage_t;

endpackage

// ===== design/fcbpm_regs.sv =====
module fcbpm_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [fcbpm_pkg::ADDR_W-1:0]    paddr,
	input  logic [fcbpm_pkg::DATA_W-1:0]    pwdata,
	output logic [fcbpm_pkg::DATA_W-1:0]    prdata,
	output logic                            pready,
	output fcbpm_pkg::cfg_t                 cfg
);

	fcbpm_pkg::cfg_t cfg_q;
	fcbpm_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx    = fcbpm_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.darkest  <= fcbpm_pkg::DARKEST_RST;
			cfg_q.dark     <= fcbpm_pkg::DARK_RST;
			cfg_q.light    <= fcbpm_pkg::LIGHT_RST;
			cfg_q.lightest <= fcbpm_pkg::LIGHTEST_RST;
			cfg_q.strength <= fcbpm_pkg::STRENGTH_RST;
		end else if (wr_en) begin
			case (idx)
				fcbpm_pkg::REG_DARKEST:  cfg_q.darkest  <= pwdata[fcbpm_pkg::PIX_W-1:0];
				fcbpm_pkg::REG_DARK:     cfg_q.dark     <= pwdata[fcbpm_pkg::PIX_W-1:0];
				fcbpm_pkg::REG_LIGHT:    cfg_q.light    <= pwdata[fcbpm_pkg::PIX_W-1:0];
				fcbpm_pkg::REG_LIGHTEST: cfg_q.lightest <= pwdata[fcbpm_pkg::PIX_W-1:0];
				fcbpm_pkg::REG_STRENGTH: cfg_q.strength <= pwdata[fcbpm_pkg::STR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			fcbpm_pkg::REG_DARKEST:  prdata = 32'(cfg_q.darkest);
			fcbpm_pkg::REG_DARK:     prdata = 32'(cfg_q.dark);
			fcbpm_pkg::REG_LIGHT:    prdata = 32'(cfg_q.light);
			fcbpm_pkg::REG_LIGHTEST: prdata = 32'(cfg_q.lightest);
			fcbpm_pkg::REG_STRENGTH: prdata = 32'(cfg_q.strength);
			default:                 prdata = '0;
		endcase
	end

endmodule

// ===== design/fcbpm_luma.sv =====
module fcbpm_luma (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [fcbpm_pkg::PIX_W-1:0]   pixel_in,
	input  logic [1:0]                    column_phase,
	input  logic [1:0]                    row_phase,
	input  logic [fcbpm_pkg::STR_W-1:0]   strength,
	output logic                          valid_s1,
	output fcbpm_pkg::luma_stage_t        stage_s1
);

	logic [24:0] sum;
	logic [16:0] lum_raw;
	logic [fcbpm_pkg::LUM_W-1:0] lum;

	always_comb begin
		sum = 25'(pixel_in[15:11]) * 25'(fcbpm_pkg::LUMA_KR)
		    + 25'(pixel_in[10:5])  * 25'(fcbpm_pkg::LUMA_KG)
		    + 25'(pixel_in[4:0])   * 25'(fcbpm_pkg::LUMA_KB)
		    + 25'd128;
		lum_raw = sum[24:8];
		lum = lum_raw[16] ? '1 : lum_raw[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		stage_s1.pixel    <= pixel_in;
		stage_s1.strength <= strength;
		stage_s1.dither   <= fcbpm_pkg::BAYER[{row_phase, column_phase}];
		stage_s1.lum      <= lum;
	end

endmodule

// ===== design/fcbpm_select.sv =====
module fcbpm_select (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  fcbpm_pkg::luma_stage_t    stage_s1,
	output logic                      valid_s2,
	output fcbpm_pkg::sel_stage_t     stage_s2
);

	function automatic logic lighter_wins(input logic [16:0] lum, input logic [16:0] lo,
			input logic [16:0] half, input logic [3:0] d);
		logic [23:0] lhs;
		logic [23:0] rhs;
		lhs = 24'(d) * 24'(half) * 24'd2;
		rhs = 24'd15 * 24'(lum - lo);
		return lhs < rhs;
	endfunction

	logic [16:0] l;
	logic [23:0] bias_lhs;
	logic [23:0] bias_rhs;
	logic top_win;
	fcbpm_pkg::pal_sel_t sel;

	always_comb begin
		l = {1'b0, stage_s1.lum};
		bias_lhs = 24'(stage_s1.dither) * 24'(fcbpm_pkg::BAND3_R) * 24'd10;
		bias_rhs = 24'd15 * (24'd3 * 24'(l - fcbpm_pkg::BAND3_LO)
		         + 24'd4 * 24'(fcbpm_pkg::BAND3_R));
		if (l > fcbpm_pkg::BIAS_POINT)
			top_win = bias_lhs < bias_rhs;
		else
			top_win = lighter_wins(l, fcbpm_pkg::BAND3_LO, fcbpm_pkg::BAND3_R,
				stage_s1.dither);

		if (l <= fcbpm_pkg::BAND1_LO)
			sel = fcbpm_pkg::PAL_DARKEST;
		else if (l <= fcbpm_pkg::BAND1_HI)
			sel = lighter_wins(l, fcbpm_pkg::BAND1_LO, fcbpm_pkg::BAND1_R, stage_s1.dither)
				? fcbpm_pkg::PAL_DARK : fcbpm_pkg::PAL_DARKEST;
		else if (l <= fcbpm_pkg::BAND2_LO)
			sel = fcbpm_pkg::PAL_DARK;
		else if (l <= fcbpm_pkg::BAND2_HI)
			sel = lighter_wins(l, fcbpm_pkg::BAND2_LO, fcbpm_pkg::BAND2_R, stage_s1.dither)
				? fcbpm_pkg::PAL_LIGHT : fcbpm_pkg::PAL_DARK;
		else if (l <= fcbpm_pkg::BAND3_LO)
			sel = fcbpm_pkg::PAL_LIGHT;
		else if (l <= fcbpm_pkg::BAND3_HI)
			sel = top_win ? fcbpm_pkg::PAL_LIGHTEST : fcbpm_pkg::PAL_LIGHT;
		else
			sel = fcbpm_pkg::PAL_LIGHTEST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		stage_s2.pixel    <= stage_s1.pixel;
		stage_s2.strength <= stage_s1.strength;
		stage_s2.sel      <= sel;
	end

endmodule

// ===== design/fcbpm_blend.sv =====
module fcbpm_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s2,
	input  fcbpm_pkg::sel_stage_t         stage_s2,
	input  fcbpm_pkg::cfg_t               cfg,
	output logic                          valid_s3,
	output logic [fcbpm_pkg::PIX_W-1:0]   pixel_s3
);

	function automatic logic [5:0] mix(input logic [5:0] a, input logic [5:0] p,
			input logic [8:0] s, input logic [5:0] maxv);
		logic [15:0] v;
		logic [7:0]  t;
		v = 16'(a) * 16'(9'd256 - s) + 16'(p) * 16'(s);
		t = v[15:8];
		return (t > 8'(maxv)) ? maxv : t[5:0];
	endfunction

	logic [fcbpm_pkg::PIX_W-1:0] pal;
	logic [fcbpm_pkg::PIX_W-1:0] mixed;
	logic [fcbpm_pkg::PIX_W-1:0] result;
	logic [5:0] r_m, g_m, b_m;

	always_comb begin
		case (stage_s2.sel)
			fcbpm_pkg::PAL_DARKEST:  pal = cfg.darkest;
			fcbpm_pkg::PAL_DARK:     pal = cfg.dark;
			fcbpm_pkg::PAL_LIGHT:    pal = cfg.light;
			fcbpm_pkg::PAL_LIGHTEST: pal = cfg.lightest;
			default:                 pal = cfg.darkest;
		endcase
		r_m = mix({1'b0, stage_s2.pixel[15:11]}, {1'b0, pal[15:11]}, stage_s2.strength, 6'd31);
		g_m = mix(stage_s2.pixel[10:5], pal[10:5], stage_s2.strength, 6'd63);
		b_m = mix({1'b0, stage_s2.pixel[4:0]}, {1'b0, pal[4:0]}, stage_s2.strength, 6'd31);
		mixed = {r_m[4:0], g_m, b_m[4:0]};
		if (stage_s2.strength == '0)
			result = stage_s2.pixel;
		else if (stage_s2.strength >= fcbpm_pkg::FULL_WEIGHT)
			result = pal;
		else
			result = mixed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		pixel_s3 <= result;
	end

endmodule

// ===== design/four_color_bayer_palette_mapper_top.sv =====
// Channel  | Signals                                   | Handshake
// input    | pixel_in, column_phase, row_phase         | start && !busy
// result   | pixel_out                                 | done, one cycle, no stall
// config   | psel penable pwrite paddr pwdata prdata   | APB, pready tied high
//
// Three register stages: luminance, band and dither select, blend.
// One item per clock; pixel_out appears together with done at the output of the blend stage.
// busy is always low; the result stage cannot be held off by the receiver.
// Asynchronous reset clears valid bits and loads the palette reset colors and reset strength.
module four_color_bayer_palette_mapper_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fcbpm_pkg::PIX_W-1:0]   pixel_in,
	input  logic [1:0]                    column_phase,
	input  logic [1:0]                    row_phase,
	output logic                          done,
	output logic [fcbpm_pkg::PIX_W-1:0]   pixel_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcbpm_pkg::ADDR_W-1:0]  paddr,
	input  logic [fcbpm_pkg::DATA_W-1:0]  pwdata,
	output logic [fcbpm_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);

	fcbpm_pkg::cfg_t cfg;
	fcbpm_pkg::luma_stage_t stage_s1;
	fcbpm_pkg::sel_stage_t stage_s2;
	logic valid_s1, valid_s2;

	assign busy = 1'b0;

	fcbpm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fcbpm_luma u_luma (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start && !busy),
		.pixel_in     (pixel_in),
		.column_phase (column_phase),
		.row_phase    (row_phase),
		.strength     (cfg.strength),
		.valid_s1     (valid_s1),
		.stage_s1     (stage_s1)
	);

	fcbpm_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.valid_s2 (valid_s2),
		.stage_s2 (stage_s2)
	);

	fcbpm_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.stage_s2 (stage_s2),
		.cfg      (cfg),
		.valid_s3 (done),
		.pixel_s3 (pixel_out)
	);

	a_item_completes: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("accepted item produced no result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 3))
		else $error("result without an accepted item");

	a_zero_strength_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cfg.strength, 3) == '0) |-> pixel_out == $past(pixel_in, 3))
		else $error("zero strength did not pass the pixel through");

endmodule
